### src/evm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_pkg
// Shared types, constants and the arctangent table for the YXZ view matrix.
// ----------------------------------------------------------------------------
package evm_pkg;

   // Default parameter values.
   localparam int DEF_ANGLE_BITS    = 16;
   localparam int DEF_FRAC_BITS     = 16;
   localparam int DEF_SINCOS_STAGES = 16;

   // Fixed-point constants of the rotator.
   localparam int ACC_FRAC   = 30;
   localparam int MAX_STAGES = 24;
   localparam int CW         = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

   // One rotator lane: vector, residual angle and quadrant.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic [1:0]           quad;
   } cordic_lane_type;

   // One beat travelling along the rotator chain (lanes: pitch, yaw, roll).
   typedef struct packed {
      logic                  valid;
      cordic_lane_type [2:0] lane;
      logic signed [31:0]    pos_x;
      logic signed [31:0]    pos_y;
      logic signed [31:0]    pos_z;
   } cordic_beat_type;

   // Cosines and sines in Q30 after quadrant correction.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] c1;
      logic signed [31:0] s1;
      logic signed [31:0] c2;
      logic signed [31:0] s2;
      logic signed [31:0] c3;
      logic signed [31:0] s3;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } trig_beat_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic signed [CW-1:0] atan_entry(input int idx);
      logic signed [CW-1:0] r;
      begin
         unique case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            default: r = 34'sd81;
         endcase
         return r;
      end
   endfunction

endpackage

### src/evm_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_cordic_cell
// One rotation step for all three angles; registers the beat for the next cell.
// ----------------------------------------------------------------------------
module evm_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  evm_pkg::cordic_beat_type beat_i,
   output evm_pkg::cordic_beat_type beat_o
);

   localparam logic signed [evm_pkg::CW-1:0] ATAN = evm_pkg::atan_entry(SHIFT);

   evm_pkg::cordic_beat_type beat_in;
   evm_pkg::cordic_beat_type beat_ff;

   // Rotate each lane towards zero residual angle; reset clears only the valid flag.
   always_comb begin
      beat_in = beat_i;
      for (int k = 0; k < 3; k++) begin
         if (!beat_i.lane[k].z[evm_pkg::CW-1]) begin
            beat_in.lane[k].x = beat_i.lane[k].x - (beat_i.lane[k].y >>> SHIFT);
            beat_in.lane[k].y = beat_i.lane[k].y + (beat_i.lane[k].x >>> SHIFT);
            beat_in.lane[k].z = beat_i.lane[k].z - ATAN;
         end else begin
            beat_in.lane[k].x = beat_i.lane[k].x + (beat_i.lane[k].y >>> SHIFT);
            beat_in.lane[k].y = beat_i.lane[k].y - (beat_i.lane[k].x >>> SHIFT);
            beat_in.lane[k].z = beat_i.lane[k].z + ATAN;
         end
      end
      beat_in.valid = beat_i.valid && !reset;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign beat_o = beat_ff;

endmodule

### src/evm_matrix_rows.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_matrix_rows
// Builds the basis vectors from sines and cosines and the translation terms.
// ----------------------------------------------------------------------------
module evm_matrix_rows #(
   parameter int FRAC_BITS = evm_pkg::DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  evm_pkg::trig_beat_type trig_i,
   output logic                   rsp_valid,
   output logic signed [17:0]     rsp_right_x,
   output logic signed [17:0]     rsp_right_y,
   output logic signed [17:0]     rsp_right_z,
   output logic signed [17:0]     rsp_up_x,
   output logic signed [17:0]     rsp_up_y,
   output logic signed [17:0]     rsp_up_z,
   output logic signed [17:0]     rsp_fwd_x,
   output logic signed [17:0]     rsp_fwd_y,
   output logic signed [17:0]     rsp_fwd_z,
   output logic signed [31:0]     rsp_trans_right,
   output logic signed [31:0]     rsp_trans_up,
   output logic signed [31:0]     rsp_trans_fwd
);

   localparam int ENT_W = FRAC_BITS + 2;
   localparam int PRD_W = ENT_W + 32;
   localparam int TW    = ENT_W + 35;
   localparam int ESH   = evm_pkg::ACC_FRAC - FRAC_BITS;
   localparam logic signed [33:0] E_LIM  = 34'sd1 <<< FRAC_BITS;
   localparam logic signed [33:0] E_HALF = 34'sd1 <<< (ESH - 1);
   localparam logic signed [63:0] Q_HALF = 64'sd1 <<< (evm_pkg::ACC_FRAC - 1);
   localparam logic signed [TW-1:0] T_HALF = TW'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [TW-1:0] T_MAX  = TW'(64'sd2147483647);
   localparam logic signed [TW-1:0] T_MIN  = TW'(-64'sd2147483648);

   // Q30 by Q30 product rounded back to Q30.
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [63:0] p;
      begin
         p = 64'(a) * 64'(b);
         return 32'((p + Q_HALF) >>> evm_pkg::ACC_FRAC);
      end
   endfunction

   // Q30 sum to a clamped matrix entry.
   function automatic logic signed [ENT_W-1:0] to_entry(input logic signed [33:0] v);
      logic signed [33:0] r;
      begin
         r = (v + E_HALF) >>> ESH;
         if (r > E_LIM) begin
            r = E_LIM;
         end else if (r < -E_LIM) begin
            r = -E_LIM;
         end
         return ENT_W'(r);
      end
   endfunction

   // Valid flags of the five stages.
   logic [4:0] vld_ff;

   // First products.
   logic signed [31:0] s1s2_ff, c1s2_ff, c1c3_ff, c2s3_ff, c3s1_ff, c2c3_ff;
   logic signed [31:0] c1s3_ff, s1s3_ff, c2s1_ff, c1c2_ff, s2_b_ff, s3_b_ff, c3_b_ff;
   logic signed [31:0] pos_b_ff [3];

   // Second products and carried terms.
   logic signed [31:0] t0_ff, t1_ff, t2_ff, t3_ff;
   logic signed [31:0] c1c3_c_ff, c2s3_c_ff, c3s1_c_ff, c2c3_c_ff;
   logic signed [31:0] c1s3_c_ff, s1s3_c_ff, c2s1_c_ff, c1c2_c_ff, s2_c_ff;
   logic signed [31:0] pos_c_ff [3];

   // Entries.
   logic signed [ENT_W-1:0] ent_d_ff [9];
   logic signed [31:0]      pos_d_ff [3];
   logic signed [ENT_W-1:0] ent_e_ff [9];
   logic signed [PRD_W-1:0] prd_ff   [9];

   // Output registers.
   logic signed [17:0] ent_out_ff [9];
   logic signed [31:0] trn_ff     [3];
   logic signed [31:0] trn_in     [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], trig_i.valid};
      end
   end

   // Stage one: products of two angle terms.
   always_ff @(posedge clock) begin
      s1s2_ff <= mul_q30(trig_i.s1, trig_i.s2);
      c1s2_ff <= mul_q30(trig_i.c1, trig_i.s2);
      c1c3_ff <= mul_q30(trig_i.c1, trig_i.c3);
      c2s3_ff <= mul_q30(trig_i.c2, trig_i.s3);
      c3s1_ff <= mul_q30(trig_i.c3, trig_i.s1);
      c2c3_ff <= mul_q30(trig_i.c2, trig_i.c3);
      c1s3_ff <= mul_q30(trig_i.c1, trig_i.s3);
      s1s3_ff <= mul_q30(trig_i.s1, trig_i.s3);
      c2s1_ff <= mul_q30(trig_i.c2, trig_i.s1);
      c1c2_ff <= mul_q30(trig_i.c1, trig_i.c2);
      s2_b_ff <= trig_i.s2;
      s3_b_ff <= trig_i.s3;
      c3_b_ff <= trig_i.c3;
      pos_b_ff[0] <= trig_i.pos_x;
      pos_b_ff[1] <= trig_i.pos_y;
      pos_b_ff[2] <= trig_i.pos_z;
   end

   // Stage two: products of three angle terms.
   always_ff @(posedge clock) begin
      t0_ff     <= mul_q30(s1s2_ff, s3_b_ff);
      t1_ff     <= mul_q30(c1s2_ff, s3_b_ff);
      t2_ff     <= mul_q30(c3_b_ff, s1s2_ff);
      t3_ff     <= mul_q30(c1s2_ff, c3_b_ff);
      c1c3_c_ff <= c1c3_ff;
      c2s3_c_ff <= c2s3_ff;
      c3s1_c_ff <= c3s1_ff;
      c2c3_c_ff <= c2c3_ff;
      c1s3_c_ff <= c1s3_ff;
      s1s3_c_ff <= s1s3_ff;
      c2s1_c_ff <= c2s1_ff;
      c1c2_c_ff <= c1c2_ff;
      s2_c_ff   <= s2_b_ff;
      pos_c_ff  <= pos_b_ff;
   end

   // Stage three: sums, rounding and clamping of the nine entries.
   always_ff @(posedge clock) begin
      ent_d_ff[0] <= to_entry(34'(c1c3_c_ff) + 34'(t0_ff));
      ent_d_ff[1] <= to_entry(34'(c2s3_c_ff));
      ent_d_ff[2] <= to_entry(34'(t1_ff) - 34'(c3s1_c_ff));
      ent_d_ff[3] <= to_entry(34'(t2_ff) - 34'(c1s3_c_ff));
      ent_d_ff[4] <= to_entry(34'(c2c3_c_ff));
      ent_d_ff[5] <= to_entry(34'(t3_ff) + 34'(s1s3_c_ff));
      ent_d_ff[6] <= to_entry(34'(c2s1_c_ff));
      ent_d_ff[7] <= to_entry(-34'(s2_c_ff));
      ent_d_ff[8] <= to_entry(34'(c1c2_c_ff));
      pos_d_ff    <= pos_c_ff;
   end

   // Stage four: entry times position.
   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         prd_ff[k] <= PRD_W'(ent_d_ff[k]) * PRD_W'(pos_d_ff[k % 3]);
      end
      ent_e_ff <= ent_d_ff;
   end

   // Stage five: negated dot product, rounded and saturated.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         logic signed [TW-1:0] acc;
         acc = -(TW'(prd_ff[3*r]) + TW'(prd_ff[3*r+1]) + TW'(prd_ff[3*r+2]));
         acc = (acc + T_HALF) >>> FRAC_BITS;
         if (acc > T_MAX) begin
            trn_in[r] = 32'(T_MAX);
         end else if (acc < T_MIN) begin
            trn_in[r] = 32'(T_MIN);
         end else begin
            trn_in[r] = 32'(acc);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         ent_out_ff[k] <= 18'(64'(ent_e_ff[k]));
      end
      trn_ff <= trn_in;
   end

   assign rsp_valid       = vld_ff[4];
   assign rsp_right_x     = ent_out_ff[0];
   assign rsp_right_y     = ent_out_ff[1];
   assign rsp_right_z     = ent_out_ff[2];
   assign rsp_up_x        = ent_out_ff[3];
   assign rsp_up_y        = ent_out_ff[4];
   assign rsp_up_z        = ent_out_ff[5];
   assign rsp_fwd_x       = ent_out_ff[6];
   assign rsp_fwd_y       = ent_out_ff[7];
   assign rsp_fwd_z       = ent_out_ff[8];
   assign rsp_trans_right = trn_ff[0];
   assign rsp_trans_up    = trn_ff[1];
   assign rsp_trans_fwd   = trn_ff[2];

endmodule

### src/euler_yxz_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix
// Camera view matrix from a position and yaw, pitch and roll angles (YXZ).
// ----------------------------------------------------------------------------
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+---------------------------
//  request   | req_pos_*, req_*_angle              | start high, busy low
//  response  | rsp_right_*, rsp_up_*, rsp_fwd_*,   | rsp_valid strobe, one cycle
//            | rsp_trans_*                         |
//
// A new beat is taken in every cycle; busy is always low.
// A beat passes through the registered rotator cells, then the quadrant
// correction register, then the product and dot-product pipe.
// Reset clears only the valid flags; beats in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix #(
   parameter int ANGLE_BITS    = evm_pkg::DEF_ANGLE_BITS,
   parameter int FRAC_BITS     = evm_pkg::DEF_FRAC_BITS,
   parameter int SINCOS_STAGES = evm_pkg::DEF_SINCOS_STAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_pitch_angle,
   input  logic [15:0]        req_yaw_angle,
   input  logic [15:0]        req_roll_angle,
   output logic               rsp_valid,
   output logic signed [17:0] rsp_right_x,
   output logic signed [17:0] rsp_right_y,
   output logic signed [17:0] rsp_right_z,
   output logic signed [17:0] rsp_up_x,
   output logic signed [17:0] rsp_up_y,
   output logic signed [17:0] rsp_up_z,
   output logic signed [17:0] rsp_fwd_x,
   output logic signed [17:0] rsp_fwd_y,
   output logic signed [17:0] rsp_fwd_z,
   output logic signed [31:0] rsp_trans_right,
   output logic signed [31:0] rsp_trans_up,
   output logic signed [31:0] rsp_trans_fwd
);

   localparam int NSTG = (SINCOS_STAGES < evm_pkg::MAX_STAGES) ?
                         SINCOS_STAGES : evm_pkg::MAX_STAGES;
   localparam int LAT  = NSTG + 6;

   // Split an angle into quadrant and residual and seed the rotator.
   function automatic evm_pkg::cordic_lane_type seed_lane(input logic [15:0] f);
      evm_pkg::cordic_lane_type l;
      logic [23:0] ext;
      logic [31:0] a;
      logic [31:0] sum;
      logic [31:0] rb;
      begin
         ext    = 24'(f);
         a      = 32'(ext[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
         sum    = a + 32'h2000_0000;
         l.quad = sum[31:30];
         rb     = a - {sum[31:30], 30'b0};
         l.x    = evm_pkg::CORDIC_GAIN;
         l.y    = '0;
         l.z    = {{2{rb[31]}}, rb};
         return l;
      end
   endfunction

   // Clamp to unit magnitude.
   function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
      begin
         if (v > evm_pkg::ONE_Q30) begin
            return 32'(evm_pkg::ONE_Q30);
         end else if (v < -evm_pkg::ONE_Q30) begin
            return 32'(-evm_pkg::ONE_Q30);
         end
         return 32'(v);
      end
   endfunction

   evm_pkg::cordic_beat_type beat [NSTG+1];
   evm_pkg::trig_beat_type   trig_in;
   evm_pkg::trig_beat_type   trig_ff;
   logic signed [31:0]       cs_c [3];
   logic signed [31:0]       cs_s [3];

   assign busy = 1'b0;

   // Head of the rotator chain.
   always_comb begin
      beat[0].valid   = start && !busy;
      beat[0].lane[0] = seed_lane(req_pitch_angle);
      beat[0].lane[1] = seed_lane(req_yaw_angle);
      beat[0].lane[2] = seed_lane(req_roll_angle);
      beat[0].pos_x   = req_pos_x;
      beat[0].pos_y   = req_pos_y;
      beat[0].pos_z   = req_pos_z;
   end

   // Row of rotator cells, one per iteration.
   for (genvar i = 0; i < NSTG; i++) begin : g_cell
      evm_cordic_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .beat_i (beat[i]),
         .beat_o (beat[i+1])
      );
   end

   // Clamp and rotate by the quadrant; reset clears only the valid flag.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [31:0] x;
         logic signed [31:0] y;
         x = clamp_unit(beat[NSTG].lane[k].x);
         y = clamp_unit(beat[NSTG].lane[k].y);
         case (beat[NSTG].lane[k].quad)
            2'd0:    begin cs_c[k] = x;  cs_s[k] = y;  end
            2'd1:    begin cs_c[k] = -y; cs_s[k] = x;  end
            2'd2:    begin cs_c[k] = -x; cs_s[k] = -y; end
            default: begin cs_c[k] = y;  cs_s[k] = -x; end
         endcase
      end
      trig_in.valid = beat[NSTG].valid && !reset;
      trig_in.c2    = cs_c[0];
      trig_in.s2    = cs_s[0];
      trig_in.c1    = cs_c[1];
      trig_in.s1    = cs_s[1];
      trig_in.c3    = cs_c[2];
      trig_in.s3    = cs_s[2];
      trig_in.pos_x = beat[NSTG].pos_x;
      trig_in.pos_y = beat[NSTG].pos_y;
      trig_in.pos_z = beat[NSTG].pos_z;
   end

   always_ff @(posedge clock) begin
      trig_ff <= trig_in;
   end

   // Product and translation pipe.
   evm_matrix_rows #(
      .FRAC_BITS (FRAC_BITS)
   ) u_rows (
      .clock           (clock),
      .reset           (reset),
      .trig_i          (trig_ff),
      .rsp_valid       (rsp_valid),
      .rsp_right_x     (rsp_right_x),
      .rsp_right_y     (rsp_right_y),
      .rsp_right_z     (rsp_right_z),
      .rsp_up_x        (rsp_up_x),
      .rsp_up_y        (rsp_up_y),
      .rsp_up_z        (rsp_up_z),
      .rsp_fwd_x       (rsp_fwd_x),
      .rsp_fwd_y       (rsp_fwd_y),
      .rsp_fwd_z       (rsp_fwd_z),
      .rsp_trans_right (rsp_trans_right),
      .rsp_trans_up    (rsp_trans_up),
      .rsp_trans_fwd   (rsp_trans_fwd)
   );

   // Every accepted beat gives a result once it has passed the whole pipeline.
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted beat gave no result");

   // No result appears without an accepted beat.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LAT !rsp_valid)
      else $error("result without accepted beat");

   // The corrected yaw cosine and pitch sine stay within unit magnitude.
   a_unit_trig: assert property (@(posedge clock) disable iff (reset)
      trig_ff.valid |-> (trig_ff.c1 <= 32'sd1073741824) && (trig_ff.c1 >= -32'sd1073741824)
                     && (trig_ff.s2 <= 32'sd1073741824) && (trig_ff.s2 >= -32'sd1073741824))
      else $error("sine or cosine beyond unit");

endmodule
